>>> src/rcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcg_pkg
// Shared types, step codes and register indexes for the Rossler chaos generator.
// ----------------------------------------------------------------------------
package rcg_pkg;

    // Coefficients that the core needs for one step.
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic [30:0]        w;
        logic [30:0]        h;
    } coef_t;

    typedef logic [4:0] step_t;

    // Sequencer steps; each step is one serial multiplication and its write back.
    localparam step_t OP_EY1  = 5'd0;
    localparam step_t OP_EZ1  = 5'd1;
    localparam step_t OP_DX1  = 5'd2;
    localparam step_t OP_DY1  = 5'd3;
    localparam step_t OP_DZ1  = 5'd4;
    localparam step_t OP_K1   = 5'd5;
    localparam step_t OP_T    = 5'd8;
    localparam step_t OP_EY2  = 5'd11;
    localparam step_t OP_EZ2  = 5'd12;
    localparam step_t OP_DX2  = 5'd13;
    localparam step_t OP_DY2  = 5'd14;
    localparam step_t OP_DZ2  = 5'd15;
    localparam step_t OP_K2   = 5'd16;
    localparam step_t OP_HALF = 5'd19;
    localparam step_t OP_FIN  = 5'd22;
    localparam step_t OP_DAC  = 5'd25;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_A0 = 3'd0;
    localparam logic [2:0] REG_B0 = 3'd1;
    localparam logic [2:0] REG_C0 = 3'd2;
    localparam logic [2:0] REG_A1 = 3'd3;
    localparam logic [2:0] REG_B1 = 3'd4;
    localparam logic [2:0] REG_C1 = 3'd5;
    localparam logic [2:0] REG_W  = 3'd6;
    localparam logic [2:0] REG_H  = 3'd7;

endpackage

>>> src/rcg_sermul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcg_sermul
// Bit-serial signed multiplier: one multiplier bit per clock, shift and add.
// ----------------------------------------------------------------------------
module rcg_sermul #(
    parameter int W = 34
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] opa,
    input  logic signed [W-1:0] opb,
    output logic                busy,
    output logic [2*W-1:0]      prod
);

    localparam int CW = $clog2(W);

    logic [W:0]    hi_reg;
    logic [W-1:0]  lo_reg;
    logic [W-1:0]  a_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [W:0]    a_ext;
    logic [W:0]    sum;

    assign a_ext = {a_reg[W-1], a_reg};

    // The last multiplier bit carries negative weight.
    always_comb
    begin
        sum = hi_reg;
        if (lo_reg[0])
        begin
            if (cnt_reg == CW'(W - 1))
                sum = hi_reg - a_ext;
            else
                sum = hi_reg + a_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= opb;
            a_reg  <= opa;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[W], sum[W:1]};
            lo_reg <= {sum[0], lo_reg[W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign prod = {hi_reg[W-1:0], lo_reg};

endmodule

>>> src/rcg_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcg_core
// Step sequencer: runs the Ralston step and the DAC scaling on one serial
// multiplier, one multiplication per sequencer step.
// ----------------------------------------------------------------------------
module rcg_core
    import rcg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  coef_t              coef,
    input  logic               res_take,
    output logic               idle,
    output logic               res_valid,
    output logic [11:0]        dac,
    output logic signed [31:0] px,
    output logic signed [31:0] py,
    output logic signed [31:0] pz
);

    localparam int F = FRAC_BITS;
    localparam logic [63:0] C23_64  = (64'd2 << F) / 64'd3;
    localparam logic [63:0] C14_64  = (64'd1 << F) / 64'd4;
    localparam logic [63:0] C34_64  = (64'd3 << F) / 64'd4;
    localparam logic [63:0] MINX_64 = (64'd95 << F) / 64'd10;
    localparam logic [63:0] MAXX_64 = (64'd1208 << F) / 64'd100;
    localparam logic [63:0] SPAN_64 = MAXX_64 + MINX_64;
    localparam logic [63:0] CDAC_64 = (64'd4095 << (2 * F)) / SPAN_64;
    localparam logic [63:0] X0_64   = (64'd1 << F) / 64'd10;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_MUL   = 5'b00100,
        S_WB    = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    step_t  op_reg, op_next;

    logic signed [31:0] y_reg [3];
    logic signed [31:0] t_reg [3];
    logic signed [31:0] k1_reg [3];
    logic signed [31:0] k2_reg [3];
    logic signed [31:0] ey_reg;
    logic signed [31:0] ez_reg;
    logic [11:0]        dac_reg;

    logic               pass2;
    logic signed [31:0] q0, q1, q2;
    logic [1:0]         idx;
    logic [33:0]        opa, opb;
    logic               mul_start;
    logic               mul_busy;
    logic [67:0]        prod;
    logic [31:0]        m32;
    logic [33:0]        dval;
    logic               dpos;

    function automatic logic [33:0] sx34(input logic [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic logic [33:0] zx34(input logic [30:0] v);
        return {3'b000, v};
    endfunction

    assign pass2 = (op_reg >= OP_EY2);
    assign q0    = pass2 ? t_reg[0] : y_reg[0];
    assign q1    = pass2 ? t_reg[1] : y_reg[1];
    assign q2    = pass2 ? t_reg[2] : y_reg[2];
    assign dval  = sx34(y_reg[0]) + MINX_64[33:0];
    assign dpos  = !dval[33] && (dval != '0);
    assign m32   = prod[F+31:F];

    // Operand selection for the current step.
    always_comb
    begin
        opa = '0;
        opb = '0;
        idx = 2'd0;
        case (op_reg) inside
            OP_EY1, OP_EY2:
            begin
                opa = sx34(coef.a);
                opb = sx34(q1);
            end
            OP_EZ1, OP_EZ2:
            begin
                opa = sx34(q2);
                opb = sx34(q0 - coef.c);
            end
            OP_DX1, OP_DX2:
            begin
                opa = zx34(coef.w);
                opb = sx34(-q1 - q2);
            end
            OP_DY1, OP_DY2:
            begin
                opa = zx34(coef.w);
                opb = sx34(ey_reg);
            end
            OP_DZ1, OP_DZ2:
            begin
                opa = zx34(coef.w);
                opb = sx34(ez_reg);
            end
            [OP_K1:OP_K1+5'd2]:
            begin
                idx = 2'(op_reg - OP_K1);
                opa = zx34(coef.h);
                opb = sx34(k1_reg[idx]);
            end
            [OP_T:OP_T+5'd2]:
            begin
                idx = 2'(op_reg - OP_T);
                opa = sx34(k1_reg[idx]);
                opb = C23_64[33:0];
            end
            [OP_K2:OP_K2+5'd2]:
            begin
                idx = 2'(op_reg - OP_K2);
                opa = zx34(coef.h);
                opb = sx34(k2_reg[idx]);
            end
            [OP_HALF:OP_HALF+5'd2]:
            begin
                idx = 2'(op_reg - OP_HALF);
                opa = sx34(k1_reg[idx]);
                opb = C14_64[33:0];
            end
            [OP_FIN:OP_FIN+5'd2]:
            begin
                idx = 2'(op_reg - OP_FIN);
                opa = sx34(k2_reg[idx]);
                opb = C34_64[33:0];
            end
            OP_DAC:
            begin
                opa = CDAC_64[33:0];
                opb = dval;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_ISSUE;
                    op_next    = OP_EY1;
                end
            end
            S_ISSUE: state_next = S_MUL;
            S_MUL:
            begin
                if (!mul_busy)
                    state_next = S_WB;
            end
            S_WB:
            begin
                if (op_reg == OP_DAC)
                    state_next = S_DONE;
                else
                begin
                    state_next = S_ISSUE;
                    op_next    = op_reg + 5'd1;
                end
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_EY1;
            y_reg[0]  <= X0_64[31:0];
            y_reg[1]  <= '0;
            y_reg[2]  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (state_reg == S_WB)
            begin
                case (op_reg) inside
                    [OP_FIN:OP_FIN+5'd2]: y_reg[idx] <= t_reg[idx] + m32;
                    default: ;
                endcase
            end
        end
    end

    // Write back of the intermediate values.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WB)
        begin
            case (op_reg) inside
                OP_EY1, OP_EY2: ey_reg <= m32 + q0;
                OP_EZ1, OP_EZ2: ez_reg <= coef.b + m32;
                OP_DX1: k1_reg[0] <= m32;
                OP_DY1: k1_reg[1] <= m32;
                OP_DZ1: k1_reg[2] <= m32;
                OP_DX2: k2_reg[0] <= m32;
                OP_DY2: k2_reg[1] <= m32;
                OP_DZ2: k2_reg[2] <= m32;
                [OP_K1:OP_K1+5'd2]: k1_reg[idx] <= m32;
                [OP_K2:OP_K2+5'd2]: k2_reg[idx] <= m32;
                [OP_T:OP_T+5'd2], [OP_HALF:OP_HALF+5'd2]: t_reg[idx] <= y_reg[idx] + m32;
                OP_DAC:
                begin
                    if (!dpos)
                        dac_reg <= '0;
                    else if (prod[67:2*F+12] != '0)
                        dac_reg <= 12'hFFF;
                    else
                        dac_reg <= prod[2*F+11:2*F];
                end
                default: ;
            endcase
        end
    end

    assign mul_start = (state_reg == S_ISSUE);

    rcg_sermul #(
        .W(34)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .opa   (opa),
        .opb   (opb),
        .busy  (mul_busy),
        .prod  (prod)
    );

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign dac       = dac_reg;
    assign px        = y_reg[0];
    assign py        = y_reg[1];
    assign pz        = y_reg[2];

endmodule

>>> src/rossler_chaos_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rossler_chaos_generator
// Rossler attractor stepped by Ralston RK2 in fixed point, with a DAC code.
// ----------------------------------------------------------------------------
// Each accepted input transaction (a tick carrying param_set) advances the
// state (x, y, z) by one Ralston second-order Runge-Kutta step using
// coefficient set 0 or 1, and produces one output transaction with the new
// state and a 12-bit DAC code of x saturated to 0..4095. All arithmetic runs
// on a single bit-serial 34x34 multiplier: a step is 26 multiplications,
// each an issue, the shift-add passes, a state that sees the multiplier
// finish and a write back; that multiplier sets the rate.
// in_stall is high while a step is in progress and while a finished
// step waits for the output register; the result lands in that register, so
// the next tick is taken while the previous result still waits on out_stall.
// The coefficients, time scale and step size sit behind an APB-style port at
// byte offsets 4*i and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module rossler_chaos_generator
    import rcg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               param_set,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [11:0]        dac_code,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic signed [31:0] pos_z_out
);

    localparam int F = FRAC_BITS;
    localparam logic [63:0] A0_RST = (64'd2 << F) / 64'd10;
    localparam logic [63:0] C0_RST = (64'd57 << F) / 64'd10;
    localparam logic [63:0] A1_RST = (64'd3 << F) / 64'd10;
    localparam logic [63:0] C1_RST = 64'd4 << F;
    localparam logic [63:0] W_RST  = 64'd200 << F;
    localparam logic [63:0] H_RST  = (64'd1 << F) / 64'd10000;

    logic signed [31:0] a0_reg, b0_reg, c0_reg, a1_reg, b1_reg, c1_reg;
    logic [30:0]        w_reg, h_reg;
    logic               set_reg;
    logic               out_valid_reg;
    logic [11:0]        dac_reg;
    logic signed [31:0] x_out_reg, y_out_reg, z_out_reg;

    logic               cfg_wr;
    logic               in_take;
    logic               out_free;
    logic               core_idle;
    logic               res_valid;
    logic               res_take;
    coef_t              coef;
    logic [11:0]        core_dac;
    logic signed [31:0] core_x, core_y, core_z;

    // Configuration register file; writes land on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg <= A0_RST[31:0];
            b0_reg <= A0_RST[31:0];
            c0_reg <= C0_RST[31:0];
            a1_reg <= A1_RST[31:0];
            b1_reg <= A1_RST[31:0];
            c1_reg <= C1_RST[31:0];
            w_reg  <= W_RST[30:0];
            h_reg  <= H_RST[30:0];
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_A0: a0_reg <= pwdata;
                REG_B0: b0_reg <= pwdata;
                REG_C0: c0_reg <= pwdata;
                REG_A1: a1_reg <= pwdata;
                REG_B1: b1_reg <= pwdata;
                REG_C1: c1_reg <= pwdata;
                REG_W:  w_reg  <= pwdata[30:0];
                REG_H:  h_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_A0:  prdata = a0_reg;
            REG_B0:  prdata = b0_reg;
            REG_C0:  prdata = c0_reg;
            REG_A1:  prdata = a1_reg;
            REG_B1:  prdata = b1_reg;
            REG_C1:  prdata = c1_reg;
            REG_W:   prdata = {1'b0, w_reg};
            REG_H:   prdata = {1'b0, h_reg};
            default: prdata = '0;
        endcase
    end

    // The tick's set choice is held for the whole step.
    assign in_stall = !core_idle;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk)
    begin
        if (in_take)
            set_reg <= param_set;
    end

    assign coef.a = set_reg ? a1_reg : a0_reg;
    assign coef.b = set_reg ? b1_reg : b0_reg;
    assign coef.c = set_reg ? c1_reg : c0_reg;
    assign coef.w = w_reg;
    assign coef.h = h_reg;

    rcg_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_take),
        .coef      (coef),
        .res_take  (res_take),
        .idle      (core_idle),
        .res_valid (res_valid),
        .dac       (core_dac),
        .px        (core_x),
        .py        (core_y),
        .pz        (core_z)
    );

    // Output register: a finished step moves in once the slot is free.
    assign out_free = !out_valid_reg || !out_stall;
    assign res_take = res_valid && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            dac_reg   <= core_dac;
            x_out_reg <= core_x;
            y_out_reg <= core_y;
            z_out_reg <= core_z;
        end
    end

    assign out_valid = out_valid_reg;
    assign dac_code  = dac_reg;
    assign pos_x_out = x_out_reg;
    assign pos_y_out = y_out_reg;
    assign pos_z_out = z_out_reg;

endmodule

>>> src/rcg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcg_checker
// Port-level checks for the Rossler chaos generator, bound to the top level.
// ----------------------------------------------------------------------------
module rcg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [11:0] dac_code,
    input logic [31:0] pos_x_out
);

    // An accepted tick keeps the input side busy while the step runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a transaction");

    // A new result appears only as the step finishes and frees the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result shown while step still busy");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(dac_code)
            && $stable(pos_x_out)))
        else $error("stalled output transaction changed");

endmodule

bind rossler_chaos_generator rcg_checker u_rcg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dac_code  (dac_code),
    .pos_x_out (pos_x_out)
);

>>> verif/rossler_chaos_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rossler_chaos_generator_tb
// Self-checking testbench for the Rossler chaos generator.
// ----------------------------------------------------------------------------
// Ticks are sent with a patterned or random parameter set. A scoreboard runs its own
// Ralston RK2 stepper in Q16.16, keeps the expected state, coefficients and
// DAC codes, and compares every output transaction field by field. The
// coefficient registers are rewritten between phases, including their
// extreme values. Sender and receiver idle at random, and at one point the
// receiver holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
module rossler_chaos_generator_tb;
    import rcg_pkg::*;

    localparam int  FB          = 16;
    localparam int  CLK_PERIOD  = 12;
    localparam longint CYCLE_LIMIT = 12_000_000;
    localparam int  STEP_LATENCY = 1100;

    // One expected output transaction.
    typedef struct {
        logic [11:0]        dac;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } rossler_sample_t;

    // Holds the stepper state, the register copy and the expected samples.
    class rossler_scoreboard;
        longint          coef_a [2];
        longint          coef_b [2];
        longint          coef_c [2];
        longint          w_rate;
        longint          h_step;
        longint          px, py, pz;
        rossler_sample_t pending_samples [$];
        int              errors;

        function new();
            coef_a[0] = 13107;  coef_b[0] = 13107;  coef_c[0] = 373555;
            coef_a[1] = 19660;  coef_b[1] = 19660;  coef_c[1] = 262144;
            w_rate = 13107200;
            h_step = 6;
            px = 6553;  py = 0;  pz = 0;
            errors = 0;
        endfunction

        function longint wrap(longint v);
            return longint'(int'(v));
        endfunction

        // Product with floor rounding, wrapped to 32 bits.
        function longint fmul(longint a, longint b);
            longint p;
            p = a * b;
            p = p >>> FB;
            return longint'(int'(p));
        endfunction

        function void slope(longint x, longint y, longint z, longint a, longint b,
                            longint c, output longint dx, output longint dy,
                            output longint dz);
            longint ex, ey, ez;
            ex = wrap(-y - z);
            ey = wrap(fmul(a, y) + x);
            ez = wrap(b + fmul(z, wrap(x - c)));
            dx = fmul(w_rate, ex);
            dy = fmul(w_rate, ey);
            dz = fmul(w_rate, ez);
        endfunction

        function logic [11:0] dac_from_x(longint x);
            longint minx, maxx, cdac, d;
            logic [63:0] q;
            minx = -((longint'(95) <<< FB) / 10);
            maxx = (longint'(1208) <<< FB) / 100;
            cdac = (longint'(4095) <<< (2 * FB)) / (maxx - minx);
            d = x - minx;
            if (d <= 0)
                return 12'd0;
            q = (64'(cdac) * 64'(d)) >> (2 * FB);
            if (q > 4095)
                return 12'd4095;
            return q[11:0];
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_A0: coef_a[0] = longint'(signed'(val));
                REG_B0: coef_b[0] = longint'(signed'(val));
                REG_C0: coef_c[0] = longint'(signed'(val));
                REG_A1: coef_a[1] = longint'(signed'(val));
                REG_B1: coef_b[1] = longint'(signed'(val));
                REG_C1: coef_c[1] = longint'(signed'(val));
                REG_W:  w_rate = longint'(val[30:0]);
                REG_H:  h_step = longint'(val[30:0]);
                default: ;
            endcase
        endfunction

        // Advances the state by one tick and queues the sample it produces.
        function void note_tick(bit set_sel);
            longint a, b, c;
            longint k1x, k1y, k1z, k2x, k2y, k2z, tx, ty, tz;
            rossler_sample_t s;
            a = coef_a[set_sel];
            b = coef_b[set_sel];
            c = coef_c[set_sel];
            slope(px, py, pz, a, b, c, k1x, k1y, k1z);
            k1x = fmul(k1x, h_step);
            k1y = fmul(k1y, h_step);
            k1z = fmul(k1z, h_step);
            tx = wrap(px + fmul(k1x, 43690));
            ty = wrap(py + fmul(k1y, 43690));
            tz = wrap(pz + fmul(k1z, 43690));
            slope(tx, ty, tz, a, b, c, k2x, k2y, k2z);
            k2x = fmul(k2x, h_step);
            k2y = fmul(k2y, h_step);
            k2z = fmul(k2z, h_step);
            px = wrap(px + fmul(k1x, 16384) + fmul(k2x, 49152));
            py = wrap(py + fmul(k1y, 16384) + fmul(k2y, 49152));
            pz = wrap(pz + fmul(k1z, 16384) + fmul(k2z, 49152));
            s.dac = dac_from_x(px);
            s.x = px[31:0];
            s.y = py[31:0];
            s.z = pz[31:0];
            pending_samples.push_back(s);
        endfunction

        function void check_sample(logic [11:0] dac, logic signed [31:0] x,
                                   logic signed [31:0] y, logic signed [31:0] z);
            rossler_sample_t s;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected output transaction dac=%0d x=%0d",
                         $time, dac, x);
                errors++;
                return;
            end
            s = pending_samples.pop_front();
            if (dac !== s.dac)
            begin
                $display("%0t: dac_code expected %0d actual %0d", $time, s.dac, dac);
                errors++;
            end
            if (x !== s.x)
            begin
                $display("%0t: pos_x_out expected %0d actual %0d", $time, s.x, x);
                errors++;
            end
            if (y !== s.y)
            begin
                $display("%0t: pos_y_out expected %0d actual %0d", $time, s.y, y);
                errors++;
            end
            if (z !== s.z)
            begin
                $display("%0t: pos_z_out expected %0d actual %0d", $time, s.z, z);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               param_set;
    logic               out_valid;
    logic               out_stall;
    logic [11:0]        dac_code;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] pos_z_out;

    rossler_scoreboard sb;
    longint            cycle_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                hold_left;
    bit                hold_request;

    rossler_chaos_generator #(.FRAC_BITS(FB)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .param_set (param_set),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dac_code  (dac_code),
        .pos_x_out (pos_x_out),
        .pos_y_out (pos_y_out),
        .pos_z_out (pos_z_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The run is cut off at a generous cycle budget in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: every output transaction is checked at the edge that accepts
    // it, then the stall for the next cycle is chosen. A hold-off request
    // keeps the stall high for a long stretch so that the output register
    // fills and the block stops taking ticks.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_sample(dac_code, pos_x_out, pos_y_out, pos_z_out);
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = 4000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Register write with a setup and an access phase, then an idle phase
    // so that psel is never dropped and raised at the same edge.
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one tick, with random gaps in front, and waits for acceptance.
    // Valid is only lowered inside a gap, so it never falls and rises at one edge.
    task automatic send_tick(bit set_sel);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        param_set <= set_sel;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_tick(set_sel);
    endtask

    // Waits until every expected sample has arrived and the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] a0, logic [31:0] b0, logic [31:0] c0,
                             logic [31:0] a1, logic [31:0] b1, logic [31:0] c1,
                             logic [31:0] w, logic [31:0] h);
        apb_write(REG_A0, a0);
        apb_write(REG_B0, b0);
        apb_write(REG_C0, c0);
        apb_write(REG_A1, a1);
        apb_write(REG_B1, b1);
        apb_write(REG_C1, c1);
        apb_write(REG_W, w);
        apb_write(REG_H, h);
    endtask

    initial
    begin
        sb            = new();
        cycle_count   = 0;
        hold_left     = 0;
        hold_request  = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        param_set     = 1'b0;
        out_stall     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the reset coefficients: both sets, back to back and
        // alternating.
        for (int i = 0; i < 10; i++)
            send_tick(i[1]);
        drain();

        // Largest coefficients, time scale and step: the state runs off and
        // wraps, and the DAC code pins at its top and bottom.
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_tick(i[0]);
        drain();

        // Most negative coefficients, zero time scale and step: no motion.
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000);
        for (int i = 0; i < 4; i++)
            send_tick(i[0]);
        drain();

        // Fully random register contents, upper bits of w and h included.
        write_all($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < 4; i++)
            send_tick(i[0]);
        drain();

        // Back near the classic attractor, with a larger step so the orbit
        // sweeps the DAC range, for the random phases.
        write_all(32'd13107, 32'd13107, 32'd373555, 32'd19660,
                  32'd19660, 32'd262144, 32'd13107200, 32'd60);
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 24 : 0;
            for (int i = 0; i < 530; i++)
            begin
                if (phase == 2 && i == 100)
                    hold_request = 1'b1;
                send_tick($urandom_range(1));
            end
            if (phase == 1)
            begin
                drain();
                apb_write(REG_H, $urandom_range(200, 1));
                apb_write(REG_C1, $urandom_range(400000, 200000));
            end
        end
        in_valid <= 1'b0;

        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (STEP_LATENCY) @(posedge clk);
        if (sb.errors == 0 && sb.pending_samples.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
